// ----- rtl/ethm_pkg.sv -----
`timescale 1ns / 1ps

package ethm_pkg;

    // Field widths fixed by the interface.
    localparam int LEVEL_W  = 16;
    localparam int TOTAL_W  = 32;
    localparam int ALPHA_W  = 9;
    localparam int PERIOD_W = 8;
    localparam int COUNT_W  = 9;
    localparam int ADDR_W   = 10;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 16;
    localparam int BEAT_W   = 2;

    // Weight that takes the new sample whole.
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE        = 9'd256;
    // Threshold code that selects digital mode.
    localparam logic [LEVEL_W-1:0]  DIGITAL_MODE     = 16'd1;
    // An erased store reads back as all ones.
    localparam logic [TOTAL_W-1:0]  ERASED_WORD      = 32'hFFFF_FFFF;
    // Seconds added per running tick.
    localparam logic [7:0]          SECONDS_PER_TICK = 8'd2;
    // Index of the final byte beat of a save.
    localparam logic [BEAT_W-1:0]   LAST_BYTE        = 2'd3;

    typedef enum logic [1:0] {
        CFG_ALPHA     = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_PERIOD    = 2'd2,
        CFG_BASE      = 2'd3
    } ethm_cfg_idx_t;

    typedef enum logic {
        REQ_SAMPLE  = 1'b0,
        REQ_RESTORE = 1'b1
    } ethm_req_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]  alpha;
        logic [LEVEL_W-1:0]  threshold;
        logic [PERIOD_W-1:0] period;
        logic [ADDR_W-1:0]   base;
    } ethm_cfg_t;

    typedef struct packed {
        logic               running;
        logic [LEVEL_W-1:0] level;
        logic [TOTAL_W-1:0] total;
        logic               save;
    } ethm_result_t;

endpackage

// ----- rtl/ethm_core.sv -----
`timescale 1ns / 1ps

module ethm_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 req_type,
    input  logic [15:0]          sample_level,
    input  logic [31:0]          saved_word,
    input  ethm_pkg::ethm_cfg_t  cfg,
    output ethm_pkg::ethm_result_t result
);
    import ethm_pkg::*;

    logic [LEVEL_W-1:0] average_reg, average_next;
    logic               run_reg, run_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [ALPHA_W-1:0]        alpha_sat;
    logic signed [LEVEL_W:0]   diff;
    logic signed [26:0]        prod;
    logic signed [26:0]        step;
    logic [LEVEL_W-1:0]        avg_filt;
    logic [COUNT_W-1:0]        count_sum;
    logic                      save;

    // Moving average written as avg + floor(a * (x - avg) / 256), one multiplier.
    always_comb
    begin
        alpha_sat = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
        diff      = $signed({1'b0, sample_level}) - $signed({1'b0, average_reg});
        prod      = $signed({1'b0, alpha_sat}) * diff;
        step      = prod >>> 8;
        avg_filt  = average_reg + step[LEVEL_W-1:0];
    end

    // State update for one item.
    always_comb
    begin
        average_next = average_reg;
        run_next     = run_reg;
        total_next   = total_reg;
        count_next   = count_reg;
        count_sum    = count_reg + COUNT_W'(SECONDS_PER_TICK);
        save         = 1'b0;
        if (ethm_req_t'(req_type) == REQ_RESTORE)
        begin
            total_next   = (saved_word == ERASED_WORD) ? '0 : saved_word;
            average_next = '0;
            run_next     = 1'b0;
            count_next   = '0;
        end
        else
        begin
            average_next = (cfg.threshold == DIGITAL_MODE) ? sample_level : avg_filt;
            run_next     = (average_next >= cfg.threshold);
            if (run_next)
            begin
                total_next = total_reg + TOTAL_W'(SECONDS_PER_TICK);
                if (count_sum >= {1'b0, cfg.period})
                begin
                    save       = 1'b1;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_sum;
                end
            end
        end
    end

    // Result set handed to the output stage.
    always_comb
    begin
        result.running = run_next;
        result.level   = average_next;
        result.total   = total_next;
        result.save    = save;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            average_reg <= '0;
            run_reg     <= 1'b0;
            total_reg   <= '0;
            count_reg   <= '0;
        end
        else if (fire)
        begin
            average_reg <= average_next;
            run_reg     <= run_next;
            total_reg   <= total_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ----- rtl/ethm_serializer.sv -----
`timescale 1ns / 1ps

module ethm_serializer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  ethm_pkg::ethm_result_t result,
    input  logic [9:0]             base,
    output logic                   can_load,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   running,
    output logic [15:0]            smoothed_level,
    output logic [31:0]            total_seconds,
    output logic                   store_write,
    output logic [9:0]             store_address,
    output logic [7:0]             store_byte,
    output logic                   last
);
    import ethm_pkg::*;

    logic                valid_reg, valid_next;
    logic [BEAT_W-1:0]   beat_reg, beat_next;
    ethm_result_t        res_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic                beat_done;
    logic [TOTAL_W-1:0]  shifted;

    // Beat fields: a save spreads over four byte beats, anything else is one beat.
    always_comb
    begin
        shifted        = res_reg.total >> {beat_reg, 3'b000};
        out_valid      = valid_reg;
        running        = res_reg.running;
        smoothed_level = res_reg.level;
        total_seconds  = res_reg.total;
        store_write    = res_reg.save;
        store_address  = res_reg.save ? base_reg + ADDR_W'(beat_reg) : '0;
        store_byte     = res_reg.save ? shifted[BYTE_W-1:0] : '0;
        last           = !res_reg.save || (beat_reg == LAST_BYTE);
    end

    // A new result set may enter when the stage is empty or its final beat leaves.
    always_comb
    begin
        beat_done  = valid_reg && out_ready;
        can_load   = !valid_reg || (beat_done && last);
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (load)
        begin
            valid_next = 1'b1;
            beat_next  = '0;
        end
        else if (beat_done)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                beat_next = beat_reg + BEAT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    // Payload of the result set.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= result;
            base_reg <= base;
        end
    end

endmodule

// ----- rtl/ema_threshold_running_hour_meter.sv -----
`timescale 1ns / 1ps
// An item is registered in the input register on acceptance, passes the combinational
// core when the output stage can take it, and is registered there as its first beat.
// Throughput: one item per cycle while each item gives one beat and out_ready stays high;
// a save gives four byte beats, and the next item waits until the last of them leaves.
// Reset (rst_n low, asynchronous) clears the state, the pipeline valids and loads
// the register defaults 64, 30, 60 and 0.

module ema_threshold_running_hour_meter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [15:0] sample_level,
    input  logic [31:0] saved_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        running,
    output logic [15:0] smoothed_level,
    output logic [31:0] total_seconds,
    output logic        store_write,
    output logic [9:0]  store_address,
    output logic [7:0]  store_byte,
    output logic        last
);
    import ethm_pkg::*;

    ethm_cfg_t          cfg_reg;
    logic               in_valid_reg, in_valid_next;
    logic               req_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [TOTAL_W-1:0] word_reg;
    logic               can_load;
    logic               fire;
    logic               in_accept;
    ethm_result_t       result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha     <= 9'd64;
            cfg_reg.threshold <= 16'd30;
            cfg_reg.period    <= 8'd60;
            cfg_reg.base      <= '0;
        end
        else if (cfg_write)
        begin
            case (ethm_cfg_idx_t'(cfg_index))
                CFG_ALPHA:     cfg_reg.alpha     <= cfg_data[ALPHA_W-1:0];
                CFG_THRESHOLD: cfg_reg.threshold <= cfg_data[LEVEL_W-1:0];
                CFG_PERIOD:    cfg_reg.period    <= cfg_data[PERIOD_W-1:0];
                CFG_BASE:      cfg_reg.base      <= cfg_data[ADDR_W-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Input register: refilled in the same cycle that its item moves on.
    always_comb
    begin
        fire          = in_valid_reg && can_load;
        in_ready      = !in_valid_reg || fire;
        in_accept     = in_valid && in_ready;
        in_valid_next = in_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg   <= req_type;
            level_reg <= sample_level;
            word_reg  <= saved_word;
        end
    end

    ethm_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .req_type     (req_reg),
        .sample_level (level_reg),
        .saved_word   (word_reg),
        .cfg          (cfg_reg),
        .result       (result)
    );

    ethm_serializer u_serializer (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (fire),
        .result         (result),
        .base           (cfg_reg.base),
        .can_load       (can_load),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .running        (running),
        .smoothed_level (smoothed_level),
        .total_seconds  (total_seconds),
        .store_write    (store_write),
        .store_address  (store_address),
        .store_byte     (store_byte),
        .last           (last)
    );

    // A processed item always shows up as a beat in the next cycle.
    a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("processed item did not reach the output stage");

    // A restore leaves the meter stopped with a cleared average.
    a_restore_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req_reg == REQ_RESTORE) |=> !running && (smoothed_level == '0) && last)
        else $error("restore result is not a cleared single beat");

    // The final byte of a save carries the top byte of the total.
    a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_write && last |-> store_byte == total_seconds[31:24])
        else $error("final save byte is not the top byte of the total");

    // The input register is never overwritten while it still holds an item.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |-> !in_ready)
        else $error("input register overwritten");

endmodule
